/* design/lit_pkg.sv */
`default_nettype none
package lit_pkg;

   localparam int unsigned DEF_TABLE_DEPTH = 64;

   localparam logic [1:0] OPC_CLEAR = 2'd0;
   localparam logic [1:0] OPC_LOAD  = 2'd1;
   localparam logic [1:0] OPC_QUERY = 2'd2;
   localparam logic [1:0] OPC_NOP   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_LOAD,
      KIND_QUERY,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } item_type;

endpackage
`default_nettype wire

/* design/lit_front.sv */
`default_nettype none
module lit_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire  [31:0]         req_tdata,
   input  wire  [1:0]          req_tuser,
   output logic                q_valid,
   output lit_pkg::item_type   q_item,
   input  wire                 q_pop
);

   lit_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   lit_pkg::item_type new_item;
   logic              push;

   always_comb begin
      case (req_tuser)
         lit_pkg::OPC_CLEAR: new_item.kind = lit_pkg::KIND_CLEAR;
         lit_pkg::OPC_LOAD:  new_item.kind = lit_pkg::KIND_LOAD;
         lit_pkg::OPC_QUERY: new_item.kind = lit_pkg::KIND_QUERY;
         default:            new_item.kind = lit_pkg::KIND_NOP;
      endcase
      new_item.x = req_tdata[15:0];
      new_item.y = req_tdata[31:16];
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3) else $error("queue fill out of range");
   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd2) && !q_pop |=> fill_ff == 2'd2) else $error("queue lost entry");

endmodule
`default_nettype wire

/* design/lit_back.sv */
`default_nettype none
module lit_back #(
   parameter int unsigned TABLE_DEPTH = lit_pkg::DEF_TABLE_DEPTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_valid,
   input  wire lit_pkg::item_type q_item,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [15:0]         rsp_tdata,
   output logic [2:0]          rsp_tuser
);

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_LD_RD, S_LD_CHK, S_Q_RD, S_Q_CHK, S_MUL, S_DVI, S_DIV, S_ADD, S_OUT
   } state_type;

   logic [15:0] x_mem [TABLE_DEPTH];
   logic [15:0] y_mem [TABLE_DEPTH];
   logic signed [15:0] x_rd_ff, y_rd_ff;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff, i_ff;
   logic [IDX_W-1:0]   k_ff;
   logic signed [15:0] px_ff, py_ff, xa_ff, ya_ff, xb_ff, yb_ff;
   logic signed [33:0] prod_ff;
   logic [16:0]        den_ff, rem_ff;
   logic [32:0]        quo_ff;
   logic               neg_ff;
   logic [5:0]         step_ff;
   logic [15:0]        val_ff;
   logic [1:0]         st_ff;
   logic               hit_ff;
   logic               rsp_valid_ff;
   logic [15:0]        rsp_val_ff;
   logic [2:0]         rsp_user_ff;

   logic               we;
   logic [IDX_W-1:0]   wa, ra;
   logic [15:0]        wx, wy;
   logic signed [16:0] dq, dy;
   logic [17:0]        trial;
   logic signed [34:0] qs, sum;
   logic [32:0]        mag;

   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      we = 1'b0;
      wa = k_ff;
      wx = px_ff;
      wy = py_ff;
      ra = k_ff - IDX_W'(1);
      case (state_ff)
         S_LD_RD: begin
            we = (k_ff == '0);
         end
         S_LD_CHK: begin
            we = 1'b1;
            if (x_rd_ff > px_ff) begin
               wx = x_rd_ff;
               wy = y_rd_ff;
            end
         end
         S_Q_RD: begin
            ra = i_ff[IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         x_mem[wa] <= wx;
         y_mem[wa] <= wy;
      end
      x_rd_ff <= x_mem[ra];
      y_rd_ff <= y_mem[ra];
   end

   always_comb begin
      dq    = 17'(px_ff) - 17'(xa_ff);
      dy    = 17'(yb_ff) - 17'(ya_ff);
      mag   = prod_ff[33] ? 33'(-prod_ff) : prod_ff[32:0];
      trial = {rem_ff, quo_ff[32]};
      qs    = neg_ff ? -35'(quo_ff) : 35'(quo_ff);
      sum   = 35'(ya_ff) + qs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_OUT reloads the response register itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  px_ff  <= q_item.x;
                  py_ff  <= q_item.y;
                  val_ff <= '0;
                  hit_ff <= 1'b0;
                  i_ff   <= '0;
                  k_ff   <= cnt_ff[IDX_W-1:0];
                  case (q_item.kind)
                     lit_pkg::KIND_CLEAR: begin
                        cnt_ff   <= '0;
                        st_ff    <= lit_pkg::ST_OK;
                        state_ff <= S_OUT;
                     end
                     lit_pkg::KIND_LOAD: begin
                        if (cnt_ff == CNT_W'(TABLE_DEPTH)) begin
                           st_ff    <= lit_pkg::ST_FULL;
                           state_ff <= S_OUT;
                        end else begin
                           st_ff    <= lit_pkg::ST_OK;
                           state_ff <= S_LD_RD;
                        end
                     end
                     lit_pkg::KIND_QUERY: begin
                        if (cnt_ff == '0) begin
                           st_ff    <= lit_pkg::ST_EMPTY;
                           state_ff <= S_OUT;
                        end else begin
                           st_ff    <= lit_pkg::ST_OK;
                           state_ff <= S_Q_RD;
                        end
                     end
                     default: begin
                        st_ff    <= lit_pkg::ST_OK;
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_LD_RD: begin
               if (k_ff == '0) begin
                  cnt_ff   <= cnt_ff + CNT_W'(1);
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_LD_CHK;
               end
            end
            S_LD_CHK: begin
               if (x_rd_ff > px_ff) begin
                  k_ff     <= k_ff - IDX_W'(1);
                  state_ff <= S_LD_RD;
               end else begin
                  cnt_ff   <= cnt_ff + CNT_W'(1);
                  state_ff <= S_OUT;
               end
            end
            S_Q_RD: state_ff <= S_Q_CHK;
            S_Q_CHK: begin
               if (x_rd_ff == px_ff) begin
                  val_ff   <= y_rd_ff;
                  hit_ff   <= 1'b1;
                  state_ff <= S_OUT;
               end else if (x_rd_ff > px_ff) begin
                  xb_ff <= x_rd_ff;
                  yb_ff <= y_rd_ff;
                  if (i_ff == '0) begin
                     st_ff    <= lit_pkg::ST_RANGE;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end else begin
                  xa_ff <= x_rd_ff;
                  ya_ff <= y_rd_ff;
                  if (i_ff + CNT_W'(1) == cnt_ff) begin
                     st_ff    <= lit_pkg::ST_RANGE;
                     state_ff <= S_OUT;
                  end else begin
                     i_ff     <= i_ff + CNT_W'(1);
                     state_ff <= S_Q_RD;
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= dq * dy;
               den_ff   <= 17'(xb_ff) - 17'(xa_ff);
               state_ff <= S_DVI;
            end
            S_DVI: begin
               neg_ff   <= prod_ff[33];
               quo_ff   <= mag;
               rem_ff   <= '0;
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring divide, one quotient bit per cycle
               if (trial >= {1'b0, den_ff}) begin
                  rem_ff <= 17'(trial - {1'b0, den_ff});
                  quo_ff <= {quo_ff[31:0], 1'b1};
               end else begin
                  rem_ff <= trial[16:0];
                  quo_ff <= {quo_ff[31:0], 1'b0};
               end
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd32) state_ff <= S_ADD;
            end
            S_ADD: begin
               if (sum > 35'sd32767) val_ff <= 16'h7fff;
               else if (sum < -35'sd32768) val_ff <= 16'h8000;
               else val_ff <= sum[15:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_val_ff   <= val_ff;
                  rsp_user_ff  <= {hit_ff, st_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH)) else $error("entry count overflow");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> den_ff != '0) else $error("zero divisor");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_Q_RD |-> i_ff < cnt_ff) else $error("scan past last entry");

endmodule
`default_nettype wire

/* design/linear_interpolation_table.sv */
// Piecewise linear interpolation table.
// Request channel req_*: tuser carries the opcode (clear/load/query/nop),
// tdata carries point_x (Q8.8) and point_y (Q4.12). Every request gives
// exactly one response on rsp_*: tdata is value (Q4.12, saturated), tuser
// holds status and the exact-hit flag.
// A two-entry queue separates the front, which accepts requests, from the
// back engine, which owns the breakpoint memory (one read, one write port).
// Clear, nop and dropped loads go straight to the response. A load is a
// shift walk over the memory port: entries above the insertion point move
// up one place each, then the new point is written. A query scans entries
// from the lowest and, when it interpolates, multiplies and then runs a
// 33-step serial divide. The back engine takes one request at a time.
// Reset empties the table and the queue; memory contents are not cleared.
// A stalled rsp_tready holds the response; the back engine then waits with
// its next result and the queue fills, after which req_tready drops.
`default_nettype none
module linear_interpolation_table #(
   parameter int unsigned TABLE_DEPTH = lit_pkg::DEF_TABLE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // point_x, point_y
   input  wire  [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // value
   output logic [2:0]  rsp_tuser    // status, exact_hit
);

   logic              q_valid;
   logic              q_pop;
   lit_pkg::item_type q_item;

   lit_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   lit_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
